[hw/rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned PAGE_COUNT_DEF = 1024;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ALLOC  = 2'd1;
    localparam logic [1:0] ST_INSIDE = 2'd2;

    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_NOMEM  = 2'd1;
    localparam logic [1:0] RES_BADFREE = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_A_SCAN,
        S_A_POP,
        S_A_UNL_PREV,
        S_A_UNL_NEXT,
        S_A_SPLIT,
        S_A_PUSH_OLD,
        S_A_FINAL,
        S_F_CHECK,
        S_F_BUDDY_RD,
        S_F_BUDDY_CHK,
        S_F_UNL_PREV,
        S_F_UNL_NEXT,
        S_F_MERGE,
        S_F_PUSH,
        S_F_PUSH_OLD,
        S_DONE
    } state_t;

endpackage

[hw/rtl/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over PAGE_COUNT page frames with LIFO free lists per order.
// ----------------------------------------------------------------------------
// An allocate scans up past empty orders, pops the head block of the first
// non-empty list and splits it down to the requested order. A free checks the
// page, then merges it with each free buddy before pushing the block. An order
// too large is answered with no memory without a scan. Throughput: one request
// at a time; the next is accepted once the result beat has gone. The page table
// allows one read and one write per cycle, and that sets the pace.
// After reset a clearing pass initialises the page table; no request is
// accepted until it ends.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // req_type[0], block_order[4:1], page_index[14:5]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // result_page[9:0], status[11:10]
);
    import bpa_pkg::*;

    localparam int unsigned AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT + 1) : 1;
    localparam int unsigned IW = $clog2(PAGE_COUNT);
    localparam int unsigned MAXO = $clog2(PAGE_COUNT + 1) - 1;
    localparam int unsigned HW = $clog2(MAXO + 1);
    localparam int unsigned OW = 5;
    localparam int unsigned MW = 2 + 4 + 2 * AW;
    localparam logic [AW-1:0] NIL = AW'(PAGE_COUNT);

    // page table word: {status, order, next, prev}
    logic [MW-1:0] mem [PAGE_COUNT];
    logic [MW-1:0] rd_q;
    logic          we;
    logic [IW-1:0] wa, ra;
    logic [MW-1:0] wd;

    logic [AW-1:0] head_reg [MAXO+1];

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] p_reg, p_next;      // current block
    logic [AW-1:0] b_reg, b_next;      // buddy / page being pushed
    logic [AW-1:0] nx_reg, nx_next, pv_reg, pv_next;
    logic [OW-1:0] k_reg, k_next, ord_reg, ord_next;
    logic          req_reg, req_next;
    logic [9:0]    pg_reg, pg_next;
    logic          ov_reg, ov_next;
    logic [9:0]    res_reg, res_next;
    logic [1:0]    st_reg, st_next;
    logic          hwe;
    logic [HW-1:0] hidx;
    logic [AW-1:0] hval;

    function automatic logic [MW-1:0] pack(logic [1:0] s, logic [3:0] o,
                                           logic [AW-1:0] n, logic [AW-1:0] p);
        return {s, o, n, p};
    endfunction

    wire [1:0]    rd_st = rd_q[MW-1 -: 2];
    wire [3:0]    rd_or = rd_q[MW-3 -: 4];
    wire [AW-1:0] rd_nx = rd_q[2*AW-1 -: AW];
    wire [AW-1:0] rd_pv = rd_q[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_q <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i <= int'(MAXO); i++)
                head_reg[i] <= (i == int'(MAXO)) ? AW'(0) : NIL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            if (hwe)
                head_reg[hidx] <= hval;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next; b_reg <= b_next; nx_reg <= nx_next; pv_reg <= pv_next;
        k_reg <= k_next; ord_reg <= ord_next; req_reg <= req_next;
        pg_reg <= pg_next; res_reg <= res_next; st_reg <= st_next;
    end

    logic [AW-1:0] bud;
    logic [HW-1:0] kh, kl;
    always_comb
    begin
        bud = p_reg ^ (AW'(1) << k_reg);
        kh  = HW'(k_reg);
        kl  = HW'(k_reg - 1'b1);
    end

    always_comb
    begin
        state_next = state_reg; cnt_next = cnt_reg; ov_next = ov_reg;
        p_next = p_reg; b_next = b_reg; nx_next = nx_reg; pv_next = pv_reg;
        k_next = k_reg; ord_next = ord_reg; req_next = req_reg; pg_next = pg_reg;
        res_next = res_reg; st_next = st_reg;
        we = 1'b0; wa = '0; wd = '0; ra = p_reg[IW-1:0];
        hwe = 1'b0; hidx = kh; hval = NIL;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1; wa = cnt_reg[IW-1:0];
                wd = (cnt_reg == '0) ? pack(ST_FREE, 4'(MAXO), NIL, NIL)
                                     : pack(ST_INSIDE, 4'd1, NIL, NIL);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(PAGE_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = !ov_reg;
                if (s_tvalid && !ov_reg)
                begin
                    req_next = s_tdata[0];
                    ord_next = {1'b0, s_tdata[4:1]};
                    k_next   = {1'b0, s_tdata[4:1]};
                    pg_next  = s_tdata[14:5];
                    p_next   = AW'(s_tdata[14:5]);
                    res_next = '0; st_next = RES_OK;
                    if (s_tdata[0] == REQ_ALLOC)
                        state_next = (s_tdata[4:1] > 4'(MAXO)) ? S_DONE : S_A_SCAN;
                    else
                        state_next = S_F_CHECK;
                    if (s_tdata[0] == REQ_ALLOC && s_tdata[4:1] > 4'(MAXO))
                        st_next = RES_NOMEM;
                end
            end
            // step up through the orders until a non-empty list appears or none is left
            S_A_SCAN:
            begin
                if (k_reg > OW'(MAXO))
                begin
                    st_next = RES_NOMEM; state_next = S_DONE;
                end
                else if (head_reg[kh] == NIL)
                    k_next = k_reg + 1'b1;
                else
                begin
                    p_next = head_reg[kh]; state_next = S_A_POP;
                end
            end
            S_A_POP:
            begin
                ra = p_reg[IW-1:0];
                state_next = S_A_UNL_PREV;
            end
            S_A_UNL_PREV:
            begin
                // popped block is a head, so prev is null: head follows next
                nx_next = rd_nx;
                hwe = 1'b1; hidx = kh; hval = rd_nx;
                state_next = (rd_nx != NIL) ? S_A_UNL_NEXT : S_A_SPLIT;
            end
            S_A_UNL_NEXT:
            begin
                ra = nx_reg[IW-1:0];
                cnt_next = '0;
                state_next = S_A_PUSH_OLD;
                b_next = nx_reg; pv_next = NIL;
            end
            S_A_SPLIT:
            begin
                if (k_reg == ord_reg)
                    state_next = S_A_FINAL;
                else
                begin
                    k_next = k_reg - 1'b1;
                    b_next = p_reg ^ (AW'(1) << (k_reg - 1'b1));
                    if ((p_reg ^ (AW'(1) << (k_reg - 1'b1))) < AW'(PAGE_COUNT))
                    begin
                        we = 1'b1;
                        wa = IW'(p_reg ^ (AW'(1) << (k_reg - 1'b1)));
                        wd = pack(ST_FREE, 4'(k_reg - 1'b1), head_reg[kl], NIL);
                        hwe = 1'b1; hidx = kl;
                        hval = p_reg ^ (AW'(1) << (k_reg - 1'b1));
                        if (head_reg[kl] != NIL)
                        begin
                            nx_next = head_reg[kl];
                            pv_next = p_reg ^ (AW'(1) << (k_reg - 1'b1));
                            ra = IW'(head_reg[kl]);
                            cnt_next = AW'(1);
                            state_next = S_A_PUSH_OLD;
                        end
                    end
                end
            end
            // rewrite prev link of a node that was read last cycle
            S_A_PUSH_OLD:
            begin
                we = 1'b1; wa = nx_reg[IW-1:0];
                wd = pack(rd_st, rd_or, rd_nx, pv_reg);
                state_next = S_A_SPLIT;
            end
            S_A_FINAL:
            begin
                we = 1'b1; wa = p_reg[IW-1:0];
                wd = pack(ST_ALLOC, ord_reg[3:0], NIL, NIL);
                res_next = 10'(p_reg);
                state_next = S_DONE;
            end
            S_F_CHECK:
            begin
                ra = p_reg[IW-1:0];
                if (int'(pg_reg) >= (1 << MAXO))
                begin
                    st_next = RES_BADFREE; state_next = S_DONE;
                end
                else
                    state_next = S_F_BUDDY_RD;
            end
            S_F_BUDDY_RD:
            begin
                if (rd_st != ST_ALLOC)
                begin
                    st_next = RES_BADFREE; state_next = S_DONE;
                end
                else
                begin
                    k_next = (OW'(rd_or) > OW'(MAXO)) ? OW'(MAXO) : OW'(rd_or);
                    state_next = S_F_BUDDY_CHK; cnt_next = '0;
                end
            end
            S_F_BUDDY_CHK:
            begin
                // issue buddy read, then check it; cnt marks read pending
                if (k_reg >= OW'(MAXO))
                    state_next = S_F_PUSH;
                else if (cnt_reg == '0)
                begin
                    ra = IW'(bud); cnt_next = AW'(1);
                end
                else
                begin
                    cnt_next = '0;
                    if (bud < AW'(PAGE_COUNT) && rd_st == ST_FREE && OW'(rd_or) == k_reg)
                    begin
                        b_next = bud; nx_next = rd_nx; pv_next = rd_pv;
                        state_next = S_F_UNL_PREV;
                    end
                    else
                        state_next = S_F_PUSH;
                end
            end
            S_F_UNL_PREV:
            begin
                if (pv_reg != NIL)
                begin
                    ra = pv_reg[IW-1:0];
                    state_next = S_F_UNL_NEXT; cnt_next = AW'(1);
                end
                else
                begin
                    hwe = 1'b1; hidx = kh; hval = nx_reg;
                    state_next = S_F_UNL_NEXT; cnt_next = '0;
                end
            end
            S_F_UNL_NEXT:
            begin
                if (cnt_reg != '0)
                begin
                    we = 1'b1; wa = pv_reg[IW-1:0];
                    wd = pack(rd_st, rd_or, nx_reg, rd_pv);
                    cnt_next = '0;
                end
                else if (nx_reg != NIL)
                begin
                    ra = nx_reg[IW-1:0];
                    state_next = S_F_MERGE; cnt_next = AW'(1);
                end
                else
                begin
                    state_next = S_F_MERGE; cnt_next = '0;
                end
            end
            S_F_MERGE:
            begin
                if (cnt_reg != '0)
                begin
                    we = 1'b1; wa = nx_reg[IW-1:0];
                    wd = pack(rd_st, rd_or, rd_nx, pv_reg);
                    cnt_next = '0;
                end
                else if (b_reg != NIL)
                begin
                    we = 1'b1; wa = b_reg[IW-1:0];
                    wd = pack(ST_INSIDE, 4'(k_reg), NIL, NIL);
                    b_next = NIL;
                end
                else
                begin
                    we = 1'b1; wa = p_reg[IW-1:0];
                    wd = pack(ST_INSIDE, 4'(k_reg), NIL, NIL);
                    p_next = p_reg & ~(AW'(1) << k_reg);
                    k_next = k_reg + 1'b1;
                    state_next = S_F_BUDDY_CHK;
                end
            end
            S_F_PUSH:
            begin
                we = 1'b1; wa = p_reg[IW-1:0];
                wd = pack(ST_FREE, 4'(k_reg), head_reg[kh], NIL);
                hwe = 1'b1; hidx = kh; hval = p_reg;
                nx_next = head_reg[kh];
                if (head_reg[kh] != NIL)
                begin
                    ra = IW'(head_reg[kh]);
                    state_next = S_F_PUSH_OLD;
                end
                else
                    state_next = S_DONE;
            end
            S_F_PUSH_OLD:
            begin
                we = 1'b1; wa = nx_reg[IW-1:0];
                wd = pack(rd_st, rd_or, rd_nx, p_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ov_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (ov_reg && m_tready)
            ov_next = 1'b0;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, st_reg, res_reg};

    // hold the result while the consumer stalls
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready) else $error("ready while busy");

    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> st_reg != 2'd3) else $error("invalid status code");
endmodule
